FILE: rtl/tsc_pkg.sv
// shared types, constants and helper functions of the token scanner
package tsc_pkg;

  localparam int unsigned PosWidth   = 16;
  localparam int unsigned NumKw      = 6;
  localparam int unsigned KwMaxLen   = 6;
  localparam int unsigned DefMaxLine = 65535;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WORD = 2'd1,
    MODE_NUM  = 2'd2
  } tsc_mode_e;

  typedef enum logic [2:0] {
    KIND_KEYWORD = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_NUMBER  = 3'd2,
    KIND_BADNUM  = 3'd3,
    KIND_OPER    = 3'd4,
    KIND_PUNCT   = 3'd5,
    KIND_UNKNOWN = 3'd6
  } tsc_kind_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
  } tsc_in_t;

  typedef struct packed {
    tsc_kind_e           token_kind;
    logic [2:0]          keyword_index;
    logic [PosWidth-1:0] token_start;
    logic [PosWidth-1:0] token_length;
    logic [7:0]          token_char;
    logic                last_of_run;
  } tsc_res_t;

  // up to two result items produced by one input item
  typedef struct packed {
    logic [1:0] count;
    tsc_res_t   r0;
    tsc_res_t   r1;
  } tsc_push_t;

  // keyword spelling, zero padded: int, float, if, else, while, return
  localparam logic [7:0] KW_TEXT [NumKw][KwMaxLen] = '{
    '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00},
    '{8'h66, 8'h6C, 8'h6F, 8'h61, 8'h74, 8'h00},
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00},
    '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65, 8'h00},
    '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E}
  };
  localparam logic [2:0] KW_LEN [NumKw] = '{3'd3, 3'd5, 3'd2, 3'd4, 3'd5, 3'd6};

  localparam logic [NumKw-1:0] KwAll = '1;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_oper(input logic [7:0] c);
    return c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h2F ||
           c == 8'h3D || c == 8'h3C || c == 8'h3E || c == 8'h21;
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return c == 8'h3B || c == 8'h2C || c == 8'h28 || c == 8'h29 ||
           c == 8'h7B || c == 8'h7D;
  endfunction

  // keep the keywords whose byte at position p equals c
  function automatic logic [NumKw-1:0] filter_kw(input logic [NumKw-1:0] mask,
                                                 input logic [PosWidth-1:0] p,
                                                 input logic [7:0] c);
    logic [NumKw-1:0] r;
    r = '0;
    for (int k = 0; k < NumKw; k++) begin
      if (mask[k] && p < PosWidth'(KW_LEN[k]) &&
          KW_TEXT[k][p[2:0]] == c) begin
        r[k] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic tsc_res_t make_res(input tsc_kind_e kind, input logic [2:0] idx,
                                        input logic [PosWidth-1:0] start,
                                        input logic [PosWidth-1:0] len,
                                        input logic [7:0] ch);
    tsc_res_t r;
    r.token_kind    = kind;
    r.keyword_index = idx;
    r.token_start   = start;
    r.token_length  = len;
    r.token_char    = ch;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  // descriptor of the open word or number
  function automatic tsc_res_t flush_res(input tsc_mode_e mode,
                                         input logic [NumKw-1:0] cands,
                                         input logic [PosWidth-1:0] start,
                                         input logic [PosWidth-1:0] len);
    tsc_kind_e  kind;
    logic [2:0] idx;
    kind = KIND_IDENT;
    idx  = '0;
    if (mode == MODE_NUM) begin
      kind = KIND_NUMBER;
    end else begin
      for (int k = 0; k < NumKw; k++) begin
        if (cands[k] && PosWidth'(KW_LEN[k]) == len) begin
          kind = KIND_KEYWORD;
          idx  = 3'(k);
        end
      end
    end
    return make_res(kind, idx, start, len, 8'h00);
  endfunction

endpackage

FILE: rtl/tsc_scan.sv
// scan state and combinational token decision logic
module tsc_scan import tsc_pkg::*; #(
  parameter int unsigned MAX_LINE_LENGTH = DefMaxLine
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  tsc_in_t   item_i,
  output tsc_push_t push_o
);

  localparam logic [PosWidth-1:0] Cap =
      (MAX_LINE_LENGTH > 65535) ? '1 : PosWidth'(MAX_LINE_LENGTH);
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChUnder = 8'h5F;

  tsc_mode_e           mode_q, mode_d, mode1;
  logic                seen_q, seen_d, seen1;
  logic [PosWidth-1:0] pos_q, pos_d;
  logic [PosWidth-1:0] start_q, start_d, start1;
  logic [PosWidth-1:0] len_q, len_d, len1, len_inc, pos_inc;
  logic [NumKw-1:0]    cands_q, cands_d, cands1;

  logic [7:0] c;
  logic word_ch, lead_ch, digit, in_word, in_num;
  logic word_ext, num_dig, num_dot, dot2, taken, flush1, scan_ch;
  logic starts_word, starts_num, single, flush2;

  tsc_res_t   res [2];
  logic [1:0] n;

  function automatic logic [PosWidth-1:0] sat_inc(input logic [PosWidth-1:0] v);
    return (v >= Cap) ? Cap : v + 1'b1;
  endfunction

  // character classes and decisions
  assign c        = item_i.char_code;
  assign digit    = is_digit(c);
  assign lead_ch  = is_letter(c) || c == ChUnder;
  assign word_ch  = lead_ch || digit;
  assign in_word  = mode_q == MODE_WORD;
  assign in_num   = mode_q == MODE_NUM;
  assign word_ext = in_word && word_ch;
  assign num_dig  = in_num && digit;
  assign num_dot  = in_num && c == ChDot;
  assign dot2     = num_dot && seen_q;
  assign taken    = word_ext || num_dig || num_dot;
  assign flush1   = (in_word && !word_ch) || (in_num && !digit && c != ChDot);
  assign scan_ch  = !taken && c != ChSpace;
  assign starts_word = scan_ch && lead_ch;
  assign starts_num  = scan_ch && digit;
  assign single      = scan_ch && !word_ch;
  assign len_inc  = sat_inc(len_q);
  assign pos_inc  = sat_inc(pos_q);

  // state after the character, before line end handling
  always_comb begin
    mode1  = MODE_IDLE;
    start1 = start_q;
    len1   = len_q;
    cands1 = cands_q;
    seen1  = seen_q;
    if (word_ext) begin
      mode1  = MODE_WORD;
      len1   = len_inc;
      cands1 = filter_kw(cands_q, len_q, c);
    end else if (num_dig || (num_dot && !dot2)) begin
      mode1 = MODE_NUM;
      len1  = len_inc;
      if (num_dot) begin
        seen1 = 1'b1;
      end
    end else begin
      if (flush1 || dot2) begin
        cands1 = KwAll;
        seen1  = 1'b0;
      end
      if (starts_word) begin
        mode1  = MODE_WORD;
        start1 = pos_q;
        len1   = PosWidth'(1);
        cands1 = filter_kw(KwAll, '0, c);
      end else if (starts_num) begin
        mode1  = MODE_NUM;
        start1 = pos_q;
        len1   = PosWidth'(1);
        seen1  = 1'b0;
      end
    end
  end

  assign flush2 = item_i.line_end && mode1 != MODE_IDLE;

  // next state
  always_comb begin
    mode_d  = mode1;
    seen_d  = seen1;
    start_d = start1;
    len_d   = len1;
    cands_d = cands1;
    pos_d   = pos_inc;
    if (item_i.line_end) begin
      mode_d  = MODE_IDLE;
      seen_d  = 1'b0;
      cands_d = KwAll;
      pos_d   = '0;
    end
  end

  // result items in emission order
  always_comb begin
    res[0] = '0;
    res[1] = '0;
    n      = 2'd0;
    if (flush1) begin
      res[0] = flush_res(mode_q, cands_q, start_q, len_q);
      n      = 2'd1;
    end else if (dot2) begin
      res[0] = make_res(KIND_BADNUM, 3'd0, start_q, len_inc, 8'h00);
      res[1] = make_res(KIND_NUMBER, 3'd0, start_q, len_inc, 8'h00);
      n      = 2'd2;
    end
    if (single) begin
      if (is_oper(c)) begin
        res[n[0]] = make_res(KIND_OPER, 3'd0, pos_q, PosWidth'(1), c);
      end else if (is_punct(c)) begin
        res[n[0]] = make_res(KIND_PUNCT, 3'd0, pos_q, PosWidth'(1), c);
      end else begin
        res[n[0]] = make_res(KIND_UNKNOWN, 3'd0, pos_q, PosWidth'(1), c);
      end
      n = n + 2'd1;
    end
    if (flush2) begin
      res[n[0]] = flush_res(mode1, cands1, start1, len1);
      n = n + 2'd1;
    end
    if (n == 2'd1) begin
      res[0].last_of_run = 1'b1;
    end else if (n == 2'd2) begin
      res[1].last_of_run = 1'b1;
    end
    push_o.count = accept_i ? n : 2'd0;
    push_o.r0    = res[0];
    push_o.r1    = res[1];
  end

  // scan state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      seen_q  <= 1'b0;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      cands_q <= KwAll;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      seen_q  <= seen_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
      cands_q <= cands_d;
    end
  end

  // nothing open means a fresh keyword mask and no decimal point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_IDLE |-> (cands_q == KwAll && !seen_q))
    else $error("idle scan state not clean");

  // an open token always has a nonzero length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != MODE_IDLE |-> len_q != '0)
    else $error("open token with zero length");

  // a line end leaves nothing open and restarts the position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && item_i.line_end |=> (mode_q == MODE_IDLE && pos_q == '0))
    else $error("line end did not flush");

endmodule

FILE: rtl/tsc_outq.sv
// three-entry result queue between the scanner and the output channel
module tsc_outq import tsc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tsc_push_t push_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output tsc_res_t  out_item_o
);

  tsc_res_t   q_q [3];
  tsc_res_t   q_d [3];
  logic [1:0] cnt_q, cnt_d, base;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_item_o  = q_q[0];
  // room for the two results a single item can cause
  assign room_o      = cnt_q <= 2'd1;

  // shift out the head, append new results behind what remains
  always_comb begin
    base   = cnt_q - {1'b0, pop};
    q_d[0] = pop ? q_q[1] : q_q[0];
    q_d[1] = pop ? q_q[2] : q_q[1];
    q_d[2] = q_q[2];
    if (push_i.count != 2'd0) begin
      q_d[base] = push_i.r0;
    end
    if (push_i.count == 2'd2) begin
      q_d[base + 2'd1] = push_i.r1;
    end
    cnt_d = base + push_i.count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  // occupancy never passes the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd3)
    else $error("result queue overflow");

  // results only arrive while there is room for a full item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count != 2'd0 |-> room_o)
    else $error("push without room");

  // output becomes valid only after a push
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(push_i.count != 2'd0))
    else $error("output valid without a pushed result");

endmodule

FILE: rtl/c_subset_token_scanner.sv
// top level of the streaming token scanner for a small c subset
//
// usage: one source byte per input item on in_item_i (char_code, line_end), with
// valid/ready handshakes on both channels. each accepted item updates the scan state
// (mode, token start and length, keyword mask, line position) in the same cycle and
// may cause zero, one or two token descriptors on out_item_o; last_of_run marks the
// last descriptor of an item. a word or number is reported when the first byte that
// cannot extend it arrives, or on the line's last byte.
// descriptors are queued as their item is taken and are offered in order from the head.
// throughput: one item per cycle while each item causes at most one descriptor and
// the receiver takes one per cycle; an item causing two descriptors holds off the
// input until the receiver has taken one. the rate is set by the three-entry result
// queue, which accepts an item only while at least two entries are free.
// reset: no item is pending, scan mode is idle and the position is zero; there is no
// clearing pass. when the receiver stalls the queue fills and in_ready_o drops; no
// descriptor is lost or repeated.
module c_subset_token_scanner import tsc_pkg::*; #(
  parameter int unsigned MAX_LINE_LENGTH = DefMaxLine
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tsc_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output tsc_res_t out_item_o
);

  tsc_push_t push;
  logic      accept;

  assign accept = in_valid_i && in_ready_o;

  tsc_scan #(
    .MAX_LINE_LENGTH(MAX_LINE_LENGTH)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .item_i  (in_item_i),
    .push_o  (push)
  );

  tsc_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule
